// ----- design/hrc_pkg.sv -----
package hrc_pkg;

  localparam int WEIGHT_BITS_DEF = 16;
  localparam int NUM_CH          = 4;
  localparam int CFG_IDX_W       = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_LOW,
    REG_RANGE_HIGH,
    REG_LOW_COLOR,
    REG_HIGH_COLOR
  } cfg_reg_e;

  localparam logic [31:0] RANGE_LOW_RST  = 32'h0000_0000;
  localparam logic [31:0] RANGE_HIGH_RST = 32'h0001_0000;
  localparam logic [31:0] LOW_COLOR_RST  = 32'h0000_00FF;
  localparam logic [31:0] HIGH_COLOR_RST = 32'hFFFF_FFFF;

  // Fixed mid-ramp green in hundredths, red first, alpha last
  localparam logic [6:0] GREEN_PCT [NUM_CH] = '{7'd26, 7'd50, 7'd24, 7'd100};

  localparam logic [6:0] BAND_EVEN = 7'd92;
  localparam logic [6:0] BAND_ODD  = 7'd106;
  localparam logic [6:0] CONT_FLAT = 7'd100;
  localparam logic [6:0] CONT_LINE = 7'd76;

  // Final divisors: segment scale * 100 * 10000, for the lower and upper segment
  localparam logic [23:0] DIV_LOW   = 24'd9_000_000;
  localparam logic [23:0] DIV_HIGH  = 24'd11_000_000;
  localparam logic [23:0] HALF_LOW  = DIV_LOW >> 1;
  localparam logic [23:0] HALF_HIGH = DIV_HIGH >> 1;

  localparam int          RECIP_SHIFT = 55;
  localparam logic [31:0] RECIP_LOW   = 32'((64'd1 << RECIP_SHIFT) / 64'(DIV_LOW));
  localparam logic [31:0] RECIP_HIGH  = 32'((64'd1 << RECIP_SHIFT) / 64'(DIV_HIGH));
  localparam int          QE_W        = 9;

  typedef logic [13:0] shade_t;

  // Band times contour of an unshaded channel
  localparam shade_t SHADE_UNITY = 14'd10000;

  function automatic shade_t shade_f(input logic odd, input logic line);
    logic [6:0] band;
    logic [6:0] cont;
    band = odd ? BAND_ODD : BAND_EVEN;
    cont = line ? CONT_LINE : CONT_FLAT;
    return 14'(band) * 14'(cont);
  endfunction

endpackage

// ----- design/height_ramp_colorizer.sv -----
// Channel  Dir  Handshake                  Payload
// cfg      in   cfg_we_i                   cfg_index_i, cfg_wdata_i
// in       in   in_valid_i / in_stall_o    height_i
// out      out  out_valid_o / out_stall_i  red_o, green_o, blue_o, alpha_o
//
// One item per cycle while the output is not stalled; WEIGHT_BITS+14 register stages
// (30 at the default). The weight divider, one quotient bit per stage, takes
// WEIGHT_BITS+1 of those stages.
// Reset clears every stage valid bit and loads the register defaults; no clearing pass.
// A stage moves when the next one is empty or moving, so bubbles close up and an
// output stall backs up stage by stage; in_stall_o rises only when the first stage
// holds an item that cannot move.
module height_ramp_colorizer
  import hrc_pkg::*;
#(
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [31:0]   height_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           red_o,
  output logic [7:0]           green_o,
  output logic [7:0]           blue_o,
  output logic [7:0]           alpha_o
);

  localparam int QB      = WEIGHT_BITS + 1;
  localparam int WX      = WEIGHT_BITS + 5;
  localparam int FW      = WEIGHT_BITS + 7;
  localparam int PW      = WEIGHT_BITS + 22;
  localparam int NW      = WEIGHT_BITS + 19;
  localparam int LW      = WEIGHT_BITS + 14;
  localparam int ST_IN   = 0;
  localparam int ST_ABS  = 1;
  localparam int ST_CMP  = 2;
  localparam int ST_DIV0 = 3;
  localparam int ST_W    = ST_DIV0 + QB;
  localparam int ST_C1   = ST_W + 1;
  localparam int ST_C2   = ST_W + 2;
  localparam int ST_C3   = ST_W + 3;
  localparam int ST_C4   = ST_W + 4;
  localparam int ST_C5   = ST_W + 5;
  localparam int ST_C6   = ST_W + 6;
  localparam int ST_C7   = ST_W + 7;
  localparam int ST_C8   = ST_W + 8;
  localparam int ST_C9   = ST_W + 9;
  localparam int NST     = ST_C9 + 1;

  localparam logic [QB-1:0] W_ONE    = QB'(1) << WEIGHT_BITS;
  localparam logic [WX-1:0] NINE_ONE = WX'(9) << WEIGHT_BITS;
  localparam logic [FW-1:0] CONT_LO  = FW'(7) << WEIGHT_BITS;
  localparam logic [FW-1:0] CONT_HI  = FW'(93) << WEIGHT_BITS;

  // Configuration registers
  logic signed [31:0] range_low_q, range_high_q;
  logic [31:0]        low_color_q, high_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= RANGE_LOW_RST;
      range_high_q <= RANGE_HIGH_RST;
      low_color_q  <= LOW_COLOR_RST;
      high_color_q <= HIGH_COLOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_RANGE_LOW:  range_low_q  <= $signed(cfg_wdata_i);
        REG_RANGE_HIGH: range_high_q <= $signed(cfg_wdata_i);
        REG_LOW_COLOR:  low_color_q  <= cfg_wdata_i;
        REG_HIGH_COLOR: high_color_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage valids and move enables
  logic [NST-1:0] vld_q, vld_d, en;

  always_comb begin
    en[NST-1] = !vld_q[NST-1] || !out_stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NST; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !en[ST_IN];
  assign out_valid_o = vld_q[ST_C9];

  // Weight front end: difference, magnitude, range test
  logic signed [32:0] in_num_q, in_rng_q;
  logic [31:0]        abs_an_q, abs_ar_q, abs_an_d, abs_ar_d;
  logic               abs_zero_q, abs_zero_d;
  logic [31:0]        cmp_r_q, cmp_ar_q;
  logic               cmp_zero_q, cmp_one_q;

  always_comb begin
    abs_zero_d = (in_rng_q == '0) || (in_num_q == '0) || (in_num_q[32] != in_rng_q[32]);
    abs_an_d   = in_num_q[32] ? 32'(-in_num_q) : in_num_q[31:0];
    abs_ar_d   = in_rng_q[32] ? 32'(-in_rng_q) : in_rng_q[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_IN]) begin
      in_num_q <= 33'(height_i) - 33'(range_low_q);
      in_rng_q <= 33'(range_high_q) - 33'(range_low_q);
    end
    if (en[ST_ABS]) begin
      abs_an_q   <= abs_an_d;
      abs_ar_q   <= abs_ar_d;
      abs_zero_q <= abs_zero_d;
    end
    if (en[ST_CMP]) begin
      cmp_r_q    <= abs_an_q;
      cmp_ar_q   <= abs_ar_q;
      cmp_zero_q <= abs_zero_q;
      cmp_one_q  <= abs_an_q >= abs_ar_q;
    end
  end

  // Restoring divider, one quotient bit per stage
  logic [31:0]   dv_r_q    [QB];
  logic [31:0]   dv_ar_q   [QB];
  logic [QB-1:0] dv_q_q    [QB];
  logic          dv_zero_q [QB];
  logic          dv_one_q  [QB];

  for (genvar d = 0; d < QB; d++) begin : g_div
    logic [31:0]   r_src, ar_src;
    logic [QB-1:0] q_src;
    logic          zero_src, one_src;
    logic [32:0]   r2;
    logic          take;
    logic [31:0]   r_d;

    if (d == 0) begin : g_first
      assign r_src    = cmp_r_q;
      assign ar_src   = cmp_ar_q;
      assign q_src    = '0;
      assign zero_src = cmp_zero_q;
      assign one_src  = cmp_one_q;
    end else begin : g_next
      assign r_src    = dv_r_q[d-1];
      assign ar_src   = dv_ar_q[d-1];
      assign q_src    = dv_q_q[d-1];
      assign zero_src = dv_zero_q[d-1];
      assign one_src  = dv_one_q[d-1];
    end

    assign r2   = {r_src, 1'b0};
    assign take = r2 >= {1'b0, ar_src};
    assign r_d  = take ? 32'(r2 - {1'b0, ar_src}) : r2[31:0];

    always_ff @(posedge clk_i) begin
      if (en[ST_DIV0+d]) begin
        dv_r_q[d]    <= r_d;
        dv_ar_q[d]   <= ar_src;
        dv_q_q[d]    <= {q_src[QB-2:0], take};
        dv_zero_q[d] <= zero_src;
        dv_one_q[d]  <= one_src;
      end
    end
  end

  // Round the quotient, which carries one bit more than the weight, to the weight
  logic [QB:0]   w_sum;
  logic [QB-1:0] w_q, w_d;

  always_comb begin
    w_sum = (QB+1)'(dv_q_q[QB-1]) + (QB+1)'(1);
    if (dv_zero_q[QB-1]) begin
      w_d = '0;
    end else if (dv_one_q[QB-1]) begin
      w_d = W_ONE;
    end else begin
      w_d = w_sum[QB:1];
    end
  end

  // Color datapath, one lane per channel
  logic [WX-1:0]      w20_q;
  logic               low2_q, low2_d;
  logic [WX-1:0]      x_q, x_d;
  shade_t             shade2_q, shade2_d;
  logic [FW-1:0]      fr100;
  logic signed [15:0] coef_q [NUM_CH];
  logic signed [15:0] coef_d [NUM_CH];
  logic [18:0]        base2_q [NUM_CH];
  logic [18:0]        base2_d [NUM_CH];
  logic [7:0]         ca, cb;
  logic [15:0]        gc255;

  always_comb begin
    low2_d   = w20_q < NINE_ONE;
    x_d      = low2_d ? w20_q : w20_q - NINE_ONE;
    fr100    = FW'(w20_q[WEIGHT_BITS-1:0]) * FW'(100);
    // band parity is bit WEIGHT_BITS+1 of 20w, since 10w = 20w/2
    shade2_d = shade_f(w20_q[WEIGHT_BITS+1], (fr100 < CONT_LO) || (fr100 > CONT_HI));
    ca       = '0;
    cb       = '0;
    gc255    = '0;
    for (int k = 0; k < NUM_CH; k++) begin
      ca    = low_color_q[8*(NUM_CH-1-k) +: 8];
      cb    = high_color_q[8*(NUM_CH-1-k) +: 8];
      gc255 = 16'(GREEN_PCT[2'(k)]) * 16'd255;
      if (low2_d) begin
        coef_d[k]  = $signed(gc255 - 16'(ca) * 16'd100);
        base2_d[k] = 19'(ca) * 19'd900;
      end else begin
        coef_d[k]  = $signed(16'(cb) * 16'd100 - gc255);
        base2_d[k] = 19'(GREEN_PCT[2'(k)]) * 19'd2805;
      end
    end
  end

  logic signed [PW-1:0] prod3_q [NUM_CH];
  logic signed [PW-1:0] prod3_d [NUM_CH];
  logic [18:0]          base3_q [NUM_CH];
  shade_t               shade3_q, shade4_q;
  logic                 low3_q, low4_q, low5_q, low6_q, low7_q, low8_q;
  logic [NW-1:0]        n4_q [NUM_CH];
  logic [NW-1:0]        n4_d [NUM_CH];
  logic signed [PW-1:0] n_sum;
  logic [32:0]          phi5_q [NUM_CH];
  logic [32:0]          phi5_d [NUM_CH];
  logic [LW-1:0]        plo5_q [NUM_CH];
  logic [LW-1:0]        plo5_d [NUM_CH];
  logic [31:0]          m6_q [NUM_CH];
  logic [31:0]          m6_d [NUM_CH];
  logic [31:0]          m7_q [NUM_CH];
  logic [QE_W-1:0]      qe7_q [NUM_CH];
  logic [QE_W-1:0]      qe7_d [NUM_CH];
  logic [63:0]          mr;
  logic [QE_W-1:0]      qe8_q [NUM_CH];
  logic [24:0]          rem8_q [NUM_CH];
  logic [24:0]          rem8_d [NUM_CH];
  logic [23:0]          div7, div8;
  logic [QE_W:0]        qf;
  logic [7:0]           out_q [NUM_CH];
  logic [7:0]           out_d [NUM_CH];
  logic                 rem_ok;
  shade_t               lane_sh;

  always_comb begin
    n_sum   = '0;
    mr      = '0;
    qf      = '0;
    lane_sh = '0;
    div7    = low7_q ? DIV_LOW : DIV_HIGH;
    div8    = low8_q ? DIV_LOW : DIV_HIGH;
    for (int k = 0; k < NUM_CH; k++) begin
      prod3_d[k] = PW'(coef_q[k]) * PW'($signed({1'b0, x_q}));
      // blend numerator; never negative, clamp anyway
      n_sum   = $signed(PW'({base3_q[k], {WEIGHT_BITS{1'b0}}})) + prod3_q[k];
      n4_d[k] = n_sum[PW-1] ? '0 : n_sum[NW-1:0];
      // alpha is blended only, never shaded
      lane_sh = (k == NUM_CH - 1) ? SHADE_UNITY : shade4_q;
      // split at the weight point so both shade products stay narrow
      phi5_d[k] = 33'(lane_sh) * 33'(n4_q[k][NW-1:WEIGHT_BITS]);
      plo5_d[k] = LW'(lane_sh) * LW'(n4_q[k][WEIGHT_BITS-1:0]);
      m6_d[k]   = 32'(34'(phi5_q[k]) + 34'(plo5_q[k] >> WEIGHT_BITS)
                      + 34'(low5_q ? HALF_LOW : HALF_HIGH));
      // reciprocal estimate is exact or one short
      mr        = 64'(m6_q[k]) * 64'(low6_q ? RECIP_LOW : RECIP_HIGH);
      qe7_d[k]  = QE_W'(mr >> RECIP_SHIFT);
      rem8_d[k] = 25'(m7_q[k] - 32'(qe7_q[k]) * 32'(div7));
      qf        = (QE_W+1)'(qe8_q[k]) + (QE_W+1)'(rem8_q[k] >= 25'(div8));
      out_d[k]  = (qf > (QE_W+1)'(255)) ? 8'hFF : qf[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_W]) begin
      w_q <= w_d;
    end
    if (en[ST_C1]) begin
      w20_q <= WX'(w_q) * WX'(20);
    end
    if (en[ST_C2]) begin
      low2_q   <= low2_d;
      x_q      <= x_d;
      shade2_q <= shade2_d;
      coef_q   <= coef_d;
      base2_q  <= base2_d;
    end
    if (en[ST_C3]) begin
      prod3_q  <= prod3_d;
      base3_q  <= base2_q;
      shade3_q <= shade2_q;
      low3_q   <= low2_q;
    end
    if (en[ST_C4]) begin
      n4_q     <= n4_d;
      shade4_q <= shade3_q;
      low4_q   <= low3_q;
    end
    if (en[ST_C5]) begin
      phi5_q <= phi5_d;
      plo5_q <= plo5_d;
      low5_q <= low4_q;
    end
    if (en[ST_C6]) begin
      m6_q   <= m6_d;
      low6_q <= low5_q;
    end
    if (en[ST_C7]) begin
      qe7_q  <= qe7_d;
      m7_q   <= m6_q;
      low7_q <= low6_q;
    end
    if (en[ST_C8]) begin
      rem8_q <= rem8_d;
      qe8_q  <= qe7_q;
      low8_q <= low7_q;
    end
    if (en[ST_C9]) begin
      out_q <= out_d;
    end
  end

  assign red_o   = out_q[0];
  assign green_o = out_q[1];
  assign blue_o  = out_q[2];
  assign alpha_o = out_q[3];

  always_comb begin
    rem_ok = 1'b1;
    for (int k = 0; k < NUM_CH; k++) begin
      rem_ok = rem_ok && (rem8_q[k] < {div8, 1'b0});
    end
  end

  a_first_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> vld_q[ST_IN])
    else $error("input stalled while first stage is empty");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_CMP] && !cmp_zero_q && !cmp_one_q) |-> (cmp_r_q < cmp_ar_q))
    else $error("divider start remainder not below divisor");

  a_w_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_W] |-> (w_q <= W_ONE))
    else $error("weight above one");

  a_recip_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_C8] |-> rem_ok)
    else $error("reciprocal estimate off by more than one");

endmodule
